// ===== src/link_silence_reboot_guard_defines.svh =====
// assertion macros shared by the link silence reboot guard modules
// no dependencies; included by files that carry concurrent checks
`ifndef LINK_SILENCE_REBOOT_GUARD_DEFINES_SVH
`define LINK_SILENCE_REBOOT_GUARD_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LSRG_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LSRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lsrg_pkg.sv =====
// shared types and constants for the link silence reboot guard
// no dependencies; imported by every module of the block
package lsrg_pkg;

    // default sizes
    localparam int STAMP_SLOTS_DEF = 64;
    localparam int ROUND_BITS_DEF  = 16;

    // field widths
    localparam int SEC_W     = 32;
    localparam int ACT_W     = 2;
    localparam int OUTCOME_W = 2;
    localparam int SILENT_W  = 16;
    localparam int RECENT_W  = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RECORD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REBOOT = 2'd2;

    // probe outcome codes
    localparam logic [OUTCOME_W-1:0] PRB_SILENT    = 2'd0;
    localparam logic [OUTCOME_W-1:0] PRB_REPLY     = 2'd1;
    localparam logic [OUTCOME_W-1:0] PRB_ERROR     = 2'd2;
    localparam logic [OUTCOME_W-1:0] PRB_NO_TARGET = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FAIL_SECONDS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DRY_RUN        = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REBOOT_CAP     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SECONDS = 2'd3;

    // register reset values and limits
    localparam logic [SEC_W-1:0]    FAIL_SECONDS_RST   = 32'd900;
    localparam logic [SEC_W-1:0]    WINDOW_SECONDS_RST = 32'd86400;
    localparam logic [RECENT_W-1:0] REBOOT_CAP_RST     = 7'd3;
    localparam logic [SEC_W-1:0]    MIN_FAIL_SECONDS   = 32'd60;
    localparam logic [RECENT_W-1:0] RECENT_MAX         = 7'd127;

    // one slot of the stamp ring with its scan tags
    typedef struct packed {
        logic [SEC_W-1:0] stamp;
        logic             valid;
        logic             expired;
        logic             pick;
    } lsrg_slot_t;

    // request from the round logic to the budget ring
    typedef struct packed {
        logic                start;
        logic [SEC_W-1:0]    now;
        logic [SEC_W-1:0]    window;
        logic [RECENT_W-1:0] reboot_cap;
    } lsrg_bud_ctl_t;

    // answer from the budget ring
    typedef struct packed {
        logic                done;
        logic                grant;
        logic [RECENT_W-1:0] recent;
    } lsrg_bud_sts_t;

endpackage

// ===== src/lsrg_stamp_cell.sv =====
// one cell of the reboot stamp ring: a stamp, its valid bit and two scan tags
// depends on lsrg_pkg
module lsrg_stamp_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  logic                     commit,
    input  logic [lsrg_pkg::SEC_W-1:0] now,
    input  lsrg_pkg::lsrg_slot_t     d,
    output lsrg_pkg::lsrg_slot_t     q
);
    import lsrg_pkg::*;

    logic [SEC_W-1:0] stamp_reg;
    logic [SEC_W-1:0] stamp_next;
    logic             valid_reg;
    logic             valid_next;
    logic             expired_reg;
    logic             expired_next;
    logic             pick_reg;
    logic             pick_next;

    // shift from the neighbor, or apply a granted budget check in place
    always_comb
    begin
        stamp_next   = stamp_reg;
        valid_next   = valid_reg;
        expired_next = expired_reg;
        pick_next    = pick_reg;
        if (shift)
        begin
            stamp_next   = d.stamp;
            valid_next   = d.valid;
            expired_next = d.expired;
            pick_next    = d.pick;
        end
        else if (commit)
        begin
            if (pick_reg)
            begin
                stamp_next = now;
                valid_next = 1'b1;
            end
            else if (expired_reg)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            expired_reg <= 1'b0;
            pick_reg    <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            expired_reg <= expired_next;
            pick_reg    <= pick_next;
        end
    end

    // stamp payload
    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

    assign q.stamp   = stamp_reg;
    assign q.valid   = valid_reg;
    assign q.expired = expired_reg;
    assign q.pick    = pick_reg;

endmodule

// ===== src/lsrg_budget.sv =====
// reboot budget: ring of stamp cells rotated past one window comparator
// depends on lsrg_pkg, lsrg_stamp_cell and the assertion macro header
`include "link_silence_reboot_guard_defines.svh"

module lsrg_budget
#(
    parameter int STAMP_SLOTS = lsrg_pkg::STAMP_SLOTS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lsrg_pkg::lsrg_bud_ctl_t ctl,
    output lsrg_pkg::lsrg_bud_sts_t sts
);
    import lsrg_pkg::*;

    localparam int CNT_W = $clog2(STAMP_SLOTS + 1);
    localparam int IDX_W = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STAMP_SLOTS - 1);

    lsrg_slot_t          ring [STAMP_SLOTS];
    lsrg_slot_t          head;
    logic [STAMP_SLOTS-1:0] pick_vec;

    logic                scanning_reg;
    logic                scanning_next;
    logic                done_reg;
    logic                done_next;
    logic                found_reg;
    logic                found_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic                in_win;
    logic                grant;
    logic                commit;

    // window test on the slot at the head of the ring, without wrap
    assign in_win = ring[0].valid &&
                    (({1'b0, ring[0].stamp} + {1'b0, ctl.window}) > {1'b0, ctl.now});

    // retag the head slot on its way to the tail
    always_comb
    begin
        head.stamp   = ring[0].stamp;
        head.valid   = ring[0].valid;
        head.expired = ring[0].valid && !in_win;
        head.pick    = !in_win && !found_reg;
    end

    // row of cells, each taking its upper neighbor, the tail taking the head
    for (genvar k = 0; k < STAMP_SLOTS; k++)
    begin : g_cell
        lsrg_slot_t d_k;
        if (k == STAMP_SLOTS - 1)
        begin : g_tail
            assign d_k = head;
        end
        else
        begin : g_mid
            assign d_k = ring[k + 1];
        end
        lsrg_stamp_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .shift  (scanning_reg),
            .commit (commit),
            .now    (ctl.now),
            .d      (d_k),
            .q      (ring[k])
        );
        assign pick_vec[k] = ring[k].pick;
    end

    // scan sequencing and count of stamps inside the window
    always_comb
    begin
        scanning_next = scanning_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        if (ctl.start)
        begin
            scanning_next = 1'b1;
            found_next    = 1'b0;
            idx_next      = '0;
            cnt_next      = '0;
        end
        else if (scanning_reg)
        begin
            if (in_win)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (!in_win)
            begin
                found_next = 1'b1;
            end
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg == IDX_LAST)
            begin
                scanning_next = 1'b0;
                done_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            scanning_reg <= scanning_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
        end
    end

    // decision in the cycle after the last shift
    assign grant  = found_reg && (32'(cnt_reg) < 32'(ctl.reboot_cap));
    assign commit = done_reg && grant;

    assign sts.done   = done_reg;
    assign sts.grant  = grant;
    assign sts.recent = (32'(cnt_reg) > 32'(RECENT_MAX)) ? RECENT_MAX : RECENT_W'(cnt_reg);

    // checks
    `LSRG_ASSERT_HOLDS(a_single_pick, clk, rst_n, done_reg, $onehot0(pick_vec),
        "more than one free slot tagged for the new stamp")
    `LSRG_ASSERT_HOLDS(a_grant_has_slot, clk, rst_n, commit, (|pick_vec),
        "budget granted with no free slot tagged")
    `LSRG_ASSERT_HOLDS(a_start_when_idle, clk, rst_n, ctl.start, (!scanning_reg && !done_reg),
        "budget check started while a scan is running")

endmodule

// ===== src/link_silence_reboot_guard.sv =====
// Link silence reboot guard. One beat in is one probe round, one beat out is its result.
// A round that clears, counts or only reads the silence streak is taken and its result
// appears in the output register on the next edge; rounds then follow back to back while
// m_axis_tready is high. A silent round whose streak reaches the silence limit with dry run
// off starts a budget check: the stamp ring of STAMP_SLOTS cells rotates once past a single
// window comparator, and the next beat is taken only after the scan result is registered.
// After a reboot result the block halts and answers every later round with action none.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while no round is in flight.
// Depends on lsrg_pkg, lsrg_budget, lsrg_stamp_cell and the assertion macro header.
`include "link_silence_reboot_guard_defines.svh"

module link_silence_reboot_guard
#(
    parameter int STAMP_SLOTS = lsrg_pkg::STAMP_SLOTS_DEF,
    parameter int ROUND_BITS  = lsrg_pkg::ROUND_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // uptime[31:0], uptime_valid[32], wall_time_s[64:33], carrier_up[65],
    // probe_outcome[67:66], zero fill[71:68]
    input  logic [lsrg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // action[1:0], elapsed_s[33:2], silent_rounds[49:34], recent_reboots[56:50],
    // streak_cleared[57], zero fill[63:58]
    output logic [lsrg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [lsrg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lsrg_pkg::SEC_W-1:0]        cfg_wdata
);
    import lsrg_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // configuration
    logic [SEC_W-1:0]    fail_seconds_reg;
    logic                dry_run_reg;
    logic [RECENT_W-1:0] reboot_cap_reg;
    logic [SEC_W-1:0]    window_seconds_reg;

    // round state
    logic                  state_reg;
    logic                  state_next;
    logic                  streak_active_reg;
    logic                  streak_active_next;
    logic [SEC_W-1:0]      streak_start_reg;
    logic [SEC_W-1:0]      streak_start_next;
    logic [ROUND_BITS-1:0] round_count_reg;
    logic [ROUND_BITS-1:0] round_count_next;
    logic                  acted_reg;
    logic                  acted_next;
    logic                  halted_reg;
    logic                  halted_next;
    logic [RECENT_W-1:0]   last_recent_reg;
    logic [RECENT_W-1:0]   last_recent_next;
    logic [SEC_W-1:0]      elapsed_hold_reg;
    logic [SEC_W-1:0]      elapsed_hold_next;
    logic [SEC_W-1:0]      wall_hold_reg;
    logic [SEC_W-1:0]      wall_hold_next;

    // output register
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [ACT_W-1:0]      action_reg;
    logic [ACT_W-1:0]      action_next;
    logic [SEC_W-1:0]      elapsed_reg;
    logic [SEC_W-1:0]      elapsed_next;
    logic [SILENT_W-1:0]   silent_reg;
    logic [SILENT_W-1:0]   silent_next;
    logic [RECENT_W-1:0]   recent_reg;
    logic [RECENT_W-1:0]   recent_next;
    logic                  cleared_reg;
    logic                  cleared_next;

    // input fields
    logic [SEC_W-1:0]      up;
    logic                  up_ok;
    logic [SEC_W-1:0]      wall;
    logic                  carrier;
    logic [OUTCOME_W-1:0]  outcome;

    logic                  accept;
    logic                  is_silent;
    logic                  eff_active;
    logic [SEC_W-1:0]      eff_start;
    logic [SEC_W-1:0]      elapsed;
    logic [SEC_W-1:0]      limit;
    logic [ROUND_BITS-1:0] count_sat;
    logic [SILENT_W-1:0]   count_field;
    logic [SILENT_W-1:0]   held_field;

    lsrg_bud_ctl_t         bud_ctl;
    lsrg_bud_sts_t         bud_sts;

    assign up      = s_axis_tdata[31:0];
    assign up_ok   = s_axis_tdata[32];
    assign wall    = s_axis_tdata[64:33];
    assign carrier = s_axis_tdata[65];
    assign outcome = s_axis_tdata[67:66];

    // handshakes: a new round enters when idle and the output slot is empty or frees this cycle
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_vld_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, cleared_reg, recent_reg, silent_reg, elapsed_reg, action_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_seconds_reg   <= FAIL_SECONDS_RST;
            dry_run_reg        <= 1'b0;
            reboot_cap_reg     <= REBOOT_CAP_RST;
            window_seconds_reg <= WINDOW_SECONDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FAIL_SECONDS:   fail_seconds_reg   <= cfg_wdata;
                REG_DRY_RUN:        dry_run_reg        <= cfg_wdata[0];
                REG_REBOOT_CAP:     reboot_cap_reg     <= cfg_wdata[RECENT_W-1:0];
                REG_WINDOW_SECONDS: window_seconds_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // silence duration as seen after this round's streak update
    assign is_silent  = (outcome == PRB_SILENT);
    assign eff_active = streak_active_reg || (is_silent && up_ok);
    assign eff_start  = streak_active_reg ? streak_start_reg : up;
    assign elapsed    = (up_ok && eff_active && (up >= eff_start)) ? (up - eff_start) : '0;
    assign limit      = (fail_seconds_reg < MIN_FAIL_SECONDS) ? MIN_FAIL_SECONDS
                                                              : fail_seconds_reg;
    assign count_sat  = (&round_count_reg) ? round_count_reg
                                           : round_count_reg + ROUND_BITS'(1);
    assign count_field = SILENT_W'(32'(count_sat));
    assign held_field  = SILENT_W'(32'(round_count_reg));

    // budget ring request
    assign bud_ctl.now        = wall_hold_reg;
    assign bud_ctl.window     = window_seconds_reg;
    assign bud_ctl.reboot_cap = reboot_cap_reg;

    // round handling
    always_comb
    begin
        state_next         = state_reg;
        streak_active_next = streak_active_reg;
        streak_start_next  = streak_start_reg;
        round_count_next   = round_count_reg;
        acted_next         = acted_reg;
        halted_next        = halted_reg;
        last_recent_next   = last_recent_reg;
        elapsed_hold_next  = elapsed_hold_reg;
        wall_hold_next     = wall_hold_reg;
        out_vld_next       = out_vld_reg && !m_axis_tready;
        action_next        = action_reg;
        elapsed_next       = elapsed_reg;
        silent_next        = silent_reg;
        recent_next        = recent_reg;
        cleared_next       = cleared_reg;
        bud_ctl.start      = 1'b0;

        if (accept)
        begin
            // default result: nothing done, counters shown as held
            out_vld_next = 1'b1;
            action_next  = ACT_NONE;
            elapsed_next = '0;
            silent_next  = held_field;
            recent_next  = last_recent_reg;
            cleared_next = 1'b0;
            if (halted_reg)
            begin
                // halted: the round is ignored
            end
            else if (!carrier || outcome == PRB_REPLY)
            begin
                cleared_next       = streak_active_reg;
                streak_active_next = 1'b0;
                streak_start_next  = '0;
                round_count_next   = '0;
                acted_next         = 1'b0;
                silent_next        = '0;
            end
            else if (!is_silent)
            begin
                // probe error or no target: report only
                elapsed_next = elapsed;
            end
            else
            begin
                round_count_next   = count_sat;
                silent_next        = count_field;
                streak_active_next = eff_active;
                streak_start_next  = eff_start;
                elapsed_next       = elapsed;
                if (elapsed >= limit && !acted_reg)
                begin
                    if (dry_run_reg)
                    begin
                        action_next = ACT_RECORD;
                        acted_next  = 1'b1;
                    end
                    else
                    begin
                        // hold the result back until the ring has been walked
                        out_vld_next      = 1'b0;
                        elapsed_hold_next = elapsed;
                        wall_hold_next    = wall;
                        bud_ctl.start     = 1'b1;
                        state_next        = S_SCAN;
                    end
                end
            end
        end
        else if (state_reg == S_SCAN && bud_sts.done)
        begin
            out_vld_next     = 1'b1;
            elapsed_next     = elapsed_hold_reg;
            silent_next      = held_field;
            recent_next      = bud_sts.recent;
            cleared_next     = 1'b0;
            last_recent_next = bud_sts.recent;
            state_next       = S_IDLE;
            if (bud_sts.grant)
            begin
                action_next = ACT_REBOOT;
                halted_next = 1'b1;
            end
            else
            begin
                action_next = ACT_RECORD;
                acted_next  = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            streak_active_reg <= 1'b0;
            streak_start_reg  <= '0;
            round_count_reg   <= '0;
            acted_reg         <= 1'b0;
            halted_reg        <= 1'b0;
            last_recent_reg   <= '0;
            out_vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            streak_active_reg <= streak_active_next;
            streak_start_reg  <= streak_start_next;
            round_count_reg   <= round_count_next;
            acted_reg         <= acted_next;
            halted_reg        <= halted_next;
            last_recent_reg   <= last_recent_next;
            out_vld_reg       <= out_vld_next;
        end
    end

    // result beat and held operands
    always_ff @(posedge clk)
    begin
        action_reg       <= action_next;
        elapsed_reg      <= elapsed_next;
        silent_reg       <= silent_next;
        recent_reg       <= recent_next;
        cleared_reg      <= cleared_next;
        elapsed_hold_reg <= elapsed_hold_next;
        wall_hold_reg    <= wall_hold_next;
    end

    lsrg_budget
    #(
        .STAMP_SLOTS (STAMP_SLOTS)
    )
    u_budget
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bud_ctl),
        .sts   (bud_sts)
    );

    // checks
    `LSRG_ASSERT_HOLDS(a_reboot_halts, clk, rst_n,
        (out_vld_reg && action_reg == ACT_REBOOT), halted_reg,
        "reboot beat shown while not halted")
    `LSRG_ASSERT_HOLDS(a_halt_with_beat, clk, rst_n, $rose(halted_reg),
        (out_vld_reg && action_reg == ACT_REBOOT), "halt entered without a reboot beat")
    `LSRG_ASSERT_HOLDS(a_scan_blocks_input, clk, rst_n, (state_reg == S_SCAN),
        (!s_axis_tready && !out_vld_reg), "round taken or beat shown during a budget scan")
    `LSRG_ASSERT_NEXT(a_start_scans, clk, rst_n, bud_ctl.start, (state_reg == S_SCAN),
        "budget check started without entering the scan state")

endmodule

// ===== dv/lsrg_round_checker.sv =====
// Result checker for the link silence reboot guard: watches the round, result and register
// channels, predicts every result and compares it field by field.
// Depends on lsrg_pkg only.
module lsrg_round_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [lsrg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lsrg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [lsrg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lsrg_pkg::SEC_W-1:0]      cfg_wdata,
    output int                              fail_count,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsrg_pkg::*;

    // probe round beat, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]           fill;
        logic [OUTCOME_W-1:0] outcome;
        logic                 carrier;
        logic [SEC_W-1:0]     wall;
        logic                 up_ok;
        logic [SEC_W-1:0]     uptime;
    } round_t;

    // verdict beat
    typedef struct packed {
        logic [5:0]          fill;
        logic                cleared;
        logic [RECENT_W-1:0] recent;
        logic [SILENT_W-1:0] silent;
        logic [SEC_W-1:0]    elapsed;
        logic [ACT_W-1:0]    action;
    } verdict_t;

    // register copy
    logic [SEC_W-1:0]    fail_s;
    logic                dry;
    logic [RECENT_W-1:0] max_rb;
    logic [SEC_W-1:0]    window_s;

    // streak and budget state
    logic                streak_on;
    logic [SEC_W-1:0]    streak_start;
    logic [SILENT_W-1:0] rounds;
    logic                acted;
    logic                halted;
    logic [SEC_W-1:0]    stamp [STAMP_SLOTS_DEF];
    logic                stamp_ok [STAMP_SLOTS_DEF];
    logic [RECENT_W-1:0] recent_held;

    verdict_t verdict_q[$];
    verdict_t got;
    verdict_t want;
    int       n_fail;

    assign fail_count = n_fail;

    // silence so far, zero without a streak, a valid uptime or when uptime went backwards
    function automatic logic [SEC_W-1:0] silence_span(input logic [SEC_W-1:0] up,
                                                      input logic up_ok);
        if (!up_ok || !streak_on || up < streak_start)
            return '0;
        return up - streak_start;
    endfunction

    // stamp still counts against the budget, sum taken one bit wider
    function automatic logic stamp_live(input logic [SEC_W-1:0] t, input logic [SEC_W-1:0] now);
        return ({1'b0, t} + {1'b0, window_s}) > {1'b0, now};
    endfunction

    // advance the guard state by one round and return its verdict
    function automatic verdict_t predict_verdict(input round_t r);
        verdict_t         v;
        logic [SEC_W-1:0] limit;
        int               live;
        int               slot;
        logic             granted;
        v = '0;
        limit = (fail_s < MIN_FAIL_SECONDS) ? MIN_FAIL_SECONDS : fail_s;
        if (halted)
        begin
            // halted: round ignored, held counts reported
        end
        else if (!r.carrier || r.outcome == PRB_REPLY)
        begin
            v.cleared    = streak_on;
            streak_on    = 1'b0;
            streak_start = '0;
            rounds       = '0;
            acted        = 1'b0;
        end
        else if (r.outcome == PRB_ERROR || r.outcome == PRB_NO_TARGET)
        begin
            v.elapsed = silence_span(r.uptime, r.up_ok);
        end
        else
        begin
            if (rounds != '1)
                rounds = rounds + 1'b1;
            if (!streak_on && r.up_ok)
            begin
                streak_on    = 1'b1;
                streak_start = r.uptime;
            end
            v.elapsed = silence_span(r.uptime, r.up_ok);
            if (v.elapsed >= limit && !acted)
            begin
                granted = 1'b0;
                if (!dry)
                begin
                    // budget check over the stamp store
                    live = 0;
                    for (int i = 0; i < STAMP_SLOTS_DEF; i++)
                        if (stamp_ok[i] && stamp_live(stamp[i], r.wall))
                            live++;
                    recent_held = (live > RECENT_MAX) ? RECENT_MAX : RECENT_W'(live);
                    if (live < max_rb && live < STAMP_SLOTS_DEF)
                    begin
                        slot = -1;
                        for (int i = 0; i < STAMP_SLOTS_DEF; i++)
                        begin
                            if (stamp_ok[i] && !stamp_live(stamp[i], r.wall))
                                stamp_ok[i] = 1'b0;
                            if (!stamp_ok[i] && slot < 0)
                                slot = i;
                        end
                        if (slot >= 0)
                        begin
                            stamp[slot]    = r.wall;
                            stamp_ok[slot] = 1'b1;
                            granted        = 1'b1;
                        end
                    end
                end
                if (granted)
                begin
                    v.action = ACT_REBOOT;
                    halted   = 1'b1;
                end
                else
                begin
                    v.action = ACT_RECORD;
                    acted    = 1'b1;
                end
            end
        end
        v.silent = rounds;
        v.recent = recent_held;
        return v;
    endfunction

    task automatic report_fault(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // watch the three channels; results first, then registers, then new rounds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_s       = FAIL_SECONDS_RST;
            dry          = 1'b0;
            max_rb       = REBOOT_CAP_RST;
            window_s     = WINDOW_SECONDS_RST;
            streak_on    = 1'b0;
            streak_start = '0;
            rounds       = '0;
            acted        = 1'b0;
            halted       = 1'b0;
            recent_held  = '0;
            for (int i = 0; i < STAMP_SLOTS_DEF; i++)
                stamp_ok[i] = 1'b0;
            verdict_q.delete();
            n_fail      = 0;
            outstanding <= 0;
        end
        else
        begin
            // compare the result beat with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = verdict_t'(m_axis_tdata);
                if (verdict_q.size() == 0)
                    report_fault($sformatf("result beat with none expected: %h", m_axis_tdata));
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.action !== want.action || got.elapsed !== want.elapsed ||
                        got.silent !== want.silent || got.recent !== want.recent ||
                        got.cleared !== want.cleared)
                        report_fault($sformatf({"result mismatch: action %0d/%0d ",
                            "elapsed %0d/%0d silent %0d/%0d recent %0d/%0d cleared %0d/%0d",
                            " (expected/actual)"},
                            want.action, got.action, want.elapsed, got.elapsed,
                            want.silent, got.silent, want.recent, got.recent,
                            want.cleared, got.cleared));
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FAIL_SECONDS:   fail_s   = cfg_wdata;
                    REG_DRY_RUN:        dry      = cfg_wdata[0];
                    REG_REBOOT_CAP:     max_rb   = cfg_wdata[RECENT_W-1:0];
                    REG_WINDOW_SECONDS: window_s = cfg_wdata;
                    default: ;
                endcase
            end

            // accepted round
            if (s_axis_tvalid && s_axis_tready)
                verdict_q.push_back(predict_verdict(round_t'(s_axis_tdata)));

            outstanding <= verdict_q.size();
        end
    end

endmodule

// ===== dv/link_silence_reboot_guard_tb.sv =====
// Top of the link silence reboot guard testbench: clock, reset, register programming and
// probe round stimulus, with random idling on both channels and the final verdict.
// Depends on lsrg_pkg, link_silence_reboot_guard and lsrg_round_checker.
module link_silence_reboot_guard_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsrg_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // uptime, uptime_valid, wall_time_s, carrier_up, probe_outcome, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // action, elapsed_s, silent_rounds, recent_reboots, streak_cleared, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [SEC_W-1:0]      cfg_wdata;

    int               fail_count;
    int               outstanding;
    logic             steady;
    logic [SEC_W-1:0] clock_up;
    logic [SEC_W-1:0] clock_wall;

    always #5 clk = ~clk;

    link_silence_reboot_guard DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    lsrg_round_checker u_round_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // result side back-pressure, none while steady
    always @(posedge clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);

    // one probe round beat; entered and left right after a rising edge
    task automatic send_round(input logic [SEC_W-1:0] up, input logic up_ok,
                              input logic [SEC_W-1:0] wall, input logic carrier,
                              input logic [OUTCOME_W-1:0] outcome);
        int gap;
        gap = 0;
        if (!steady)
            while (gap < 10 && $urandom_range(0, 99) < 33)
                gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, outcome, carrier, wall, up_ok, up};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // all four registers, written back to back
    task automatic program_regs(input logic [SEC_W-1:0] fail, input logic dry,
                                input logic [RECENT_W-1:0] max_rb,
                                input logic [SEC_W-1:0] window);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FAIL_SECONDS;
        cfg_wdata <= fail;
        @(posedge clk);
        cfg_addr  <= REG_DRY_RUN;
        cfg_wdata <= {{(SEC_W-1){1'b0}}, dry};
        @(posedge clk);
        cfg_addr  <= REG_REBOOT_CAP;
        cfg_wdata <= {{(SEC_W-RECENT_W){1'b0}}, max_rb};
        @(posedge clk);
        cfg_addr  <= REG_WINDOW_SECONDS;
        cfg_wdata <= window;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold rounds back until every predicted result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // silence episodes with random content, ended by a reply or a carrier drop, plus noise
    task automatic run_episodes(input int n_items, input logic [SEC_W-1:0] step_max);
        int   sent;
        int   len;
        int   pick;
        logic [OUTCOME_W-1:0] outcome;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_round($urandom, 1'($urandom_range(0, 1)), $urandom,
                           1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 1))
                    clock_up = $urandom;
                len = $urandom_range(1, 30);
                for (int k = 0; k < len && sent < n_items; k++)
                begin
                    pick = $urandom_range(0, 99);
                    outcome = (pick < 75) ? PRB_SILENT : (pick < 88) ? PRB_ERROR : PRB_NO_TARGET;
                    clock_up   = clock_up + $urandom_range(0, step_max);
                    clock_wall = clock_wall + $urandom_range(0, 5000);
                    send_round(clock_up, $urandom_range(0, 99) >= 8, clock_wall, 1'b1, outcome);
                    sent++;
                end
                if ($urandom_range(0, 1))
                    send_round(clock_up, 1'b1, clock_wall, 1'b1, PRB_REPLY);
                else
                    send_round(clock_up, 1'($urandom_range(0, 1)), clock_wall, 1'b0,
                               2'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    // run limit
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [SEC_W-1:0] fail;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_FAIL_SECONDS;
        cfg_wdata     <= '0;
        steady        = 1'b0;
        clock_up      = '0;
        clock_wall    = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rounds: limit below the floor, zero window, empty budget
        program_regs('0, 1'b0, '0, '0);
        send_round(32'd0, 1'b1, 32'd0, 1'b0, PRB_SILENT);
        send_round(32'd0, 1'b1, 32'd0, 1'b1, PRB_REPLY);
        send_round(32'd10, 1'b1, 32'd5, 1'b1, PRB_ERROR);
        send_round(32'd20, 1'b1, 32'd5, 1'b1, PRB_NO_TARGET);
        // silent round with bad uptime counts but starts nothing
        send_round(32'd90, 1'b0, 32'd6, 1'b1, PRB_SILENT);
        send_round(32'd100, 1'b1, 32'd7, 1'b1, PRB_SILENT);
        send_round(32'd130, 1'b1, 32'd8, 1'b1, PRB_ERROR);
        // uptime behind the streak start
        send_round(32'd50, 1'b1, 32'd9, 1'b1, PRB_NO_TARGET);
        send_round(32'd159, 1'b1, 32'd10, 1'b1, PRB_SILENT);
        // reaches the floor limit, budget of zero refuses
        send_round(32'd160, 1'b1, 32'd11, 1'b1, PRB_SILENT);
        send_round(32'd5000, 1'b1, 32'd12, 1'b1, PRB_SILENT);
        send_round(32'd5001, 1'b0, 32'd13, 1'b1, PRB_SILENT);
        send_round(32'd5002, 1'b1, 32'd14, 1'b1, PRB_REPLY);
        send_round(32'hFFFF_FF00, 1'b1, 32'hFFFF_FFFF, 1'b1, PRB_SILENT);
        send_round(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, PRB_SILENT);
        send_round(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, PRB_NO_TARGET);
        send_round(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, PRB_REPLY);
        send_round(32'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, PRB_SILENT);
        // widest possible silence
        send_round(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b1, PRB_SILENT);
        send_round(32'd10, 1'b1, 32'h7FFF_FFFF, 1'b1, PRB_ERROR);
        send_round(32'd11, 1'b1, 32'h0, 1'b1, PRB_REPLY);
        drain();

        // long silent streak with a dry run record, no idling here
        program_regs(MIN_FAIL_SECONDS, 1'b1, 7'd64, 32'hFFFF_FFFF);
        steady = 1'b1;
        for (int i = 0; i < 40; i++)
            send_round(32'(i * 7), 1'b1, $urandom, 1'b1, PRB_SILENT);
        send_round(32'd0, 1'b1, 32'd0, 1'b1, PRB_REPLY);
        steady = 1'b0;
        drain();

        // dry run with the floor limit
        run_episodes(200, 32'd30);
        drain();

        // budget of zero: every action goes through a refused check
        fail = $urandom_range(60, 3000);
        program_regs(fail, 1'b0, '0, $urandom);
        run_episodes(200, fail / 4 + 1);
        drain();

        // largest limit, huge uptime steps, no idling
        program_regs(32'hFFFF_FFFF, 1'b1, 7'($urandom_range(0, 64)), WINDOW_SECONDS_RST);
        steady = 1'b1;
        run_episodes(200, 32'h3FFF_FFFF);
        steady = 1'b0;
        drain();

        // budget granted: reboot, then the block stays halted
        fail = $urandom_range(60, 600);
        program_regs(fail, 1'b0, 7'($urandom_range(1, 64)), $urandom);
        run_episodes(60, fail / 4 + 1);
        drain();

        repeat (100) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
